// File: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is high.
`define HAV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define HAV_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hav_pkg.sv
`default_nettype none

package hav_pkg;

  // Fraction bits of the input angles.
  localparam int ANGLE_FRAC_BITS = 16;

  // Degrees to Q32 turns: round(2^40 / 360).
  localparam logic [31:0] DEG_TURN_K = 32'd3054198966;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;
  localparam logic [30:0] SEARCH_MSB = 31'h40000000;

  localparam logic [12:0] RADIUS_RESET = 13'd6371;
  localparam logic [22:0] DIST_MAX = 23'h7FFFFF;
  localparam logic [44:0] DIST_ROUND = 45'd1048576;

  // Register index of the radius, taken from the word address.
  localparam logic REG_RADIUS_IDX = 1'b0;

  // Series evaluation: terms after the first, and pipeline depth.
  localparam int TERMS = 10;
  localparam int TAYLOR_LAT = 3 * TERMS + 2;
  localparam int ROOT_STEPS = 31;
  localparam int SEARCH_STEPS = 31;

  // Divisors of the series terms and floor(2^31 / divisor).
  localparam logic [8:0] SIN_DIV [TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
  localparam logic [30:0] SIN_RECIP [TERMS] = '{
    31'd357913941, 31'd107374182, 31'd51130563, 31'd29826161, 31'd19522578,
    31'd13765920, 31'd10226112, 31'd7895160, 31'd6279191, 31'd5113056};
  localparam logic [8:0] COS_DIV [TERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};
  localparam logic [30:0] COS_RECIP [TERMS] = '{
    31'd1073741824, 31'd178956970, 31'd71582788, 31'd38347922, 31'd23860929,
    31'd16268815, 31'd11799360, 31'd8947848, 31'd7017920, 31'd5651272};

  typedef logic [30:0] q30_t;

  typedef struct packed {
    logic valid;
    logic missing;
  } tag_t;

  typedef struct packed {
    logic [61:0] rad;
    logic [31:0] rem;
    logic [30:0] root;
  } root_lane_t;

  typedef struct packed {
    tag_t       tag;
    root_lane_t u;
    root_lane_t v;
  } root_item_t;

  typedef struct packed {
    tag_t tag;
    q30_t theta;
    q30_t mask;
    q30_t u;
    q30_t v;
  } search_item_t;

endpackage

`default_nettype wire

// File: rtl/core/haversine_great_circle_distance.sv
// Great-circle distance of two points by the haversine formula. One point
// pair is accepted per clock while the skid register is empty, and results
// leave in the same order, one per item. Most of the pipeline is the angle
// search: a chain of 31 cells, each running a 32-stage sine/cosine series
// followed by a multiply and a compare; ahead of it lie the front end and
// the two 31-step square-root chains.
// The radius register (word 0) may only be written while no item is in
// flight. When either point lacks data, missing is set and the distance is 0.
`default_nettype none

module haversine_great_circle_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] lat_a,
  input  logic signed [24:0] lon_a,
  input  logic signed [23:0] lat_b,
  input  logic signed [24:0] lon_b,
  input  logic               geo_valid_a,
  input  logic               geo_valid_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [22:0]        distance_km,
  output logic               missing,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = hav_pkg::TAYLOR_LAT;
  localparam int NR  = hav_pkg::ROOT_STEPS;
  localparam int NS  = hav_pkg::SEARCH_STEPS;

  typedef struct packed {
    hav_pkg::tag_t tag;
    logic [1:0]    qdl;
    logic [1:0]    qdn;
    logic [1:0]    qa;
    logic [1:0]    qb;
  } front_t;

  logic        en;
  logic [12:0] earth_radius_km;

  // Stage 1: angle magnitudes.
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  hav_pkg::tag_t s1_tag;
  logic [24:0]   s1_mdlat;
  logic [25:0]   s1_mdlon;
  logic [23:0]   s1_mla, s1_mlb;

  // Stage 2: phases in turns.
  logic [57:0]   pm_dlat, pm_dlon, pm_la, pm_lb;
  hav_pkg::tag_t s2_tag;
  logic [31:0]   s2_pdlat, s2_pdlon, s2_pla, s2_plb;

  // Stage 3: quadrant reduction.
  logic [60:0]   rm_dlat, rm_dlon, rm_la, rm_lb;
  front_t        s3_front;
  hav_pkg::q30_t s3_tdlat, s3_tdlon, s3_tla, s3_tlb;

  // Series lanes and the side line beside them.
  hav_pkg::q30_t sin_dl, cos_dl, sin_dn, cos_dn, sin_a, cos_a, sin_b, cos_b;
  front_t        fl [0:LAT-1];

  // Stages 4 to 6: h.
  hav_pkg::q30_t sel_dl, sel_dn, sel_a, sel_b;
  logic [61:0]   sq_dl, sq_dn, pr_ab, pr_h;
  hav_pkg::tag_t s4_tag, s5_tag;
  hav_pkg::q30_t s4_sd2, s4_so2, s4_cc, s5_sd2, s5_prod;
  logic          s4_neg, s5_neg;
  logic signed [32:0] hv;
  hav_pkg::q30_t      h;
  hav_pkg::root_item_t root_in;
  hav_pkg::root_item_t root_c [0:NR];

  // Angle search and scaling.
  hav_pkg::search_item_t srch_c [0:NS];
  hav_pkg::tag_t p1_tag;
  logic [43:0]   p1_prod;
  logic [44:0]   rnd;
  logic [22:0]   dist_sat;

  // Output register and skid register.
  logic        skid_valid;
  logic [22:0] skid_dist;
  logic        skid_missing;

  assign en       = !skid_valid;
  assign in_ready = en;

  // Radius register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hav_pkg::REG_RADIUS_IDX) ? 32'(earth_radius_km) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_km <= hav_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == hav_pkg::REG_RADIUS_IDX) begin
      earth_radius_km <= pwdata[12:0];
    end
  end

  // Differences and magnitudes; cosine and squared sine are even.
  assign dlat = {lat_b[23], lat_b} - {lat_a[23], lat_a};
  assign dlon = {lon_b[24], lon_b} - {lon_a[24], lon_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else if (en) begin
      s1_tag.valid   <= in_valid;
      s1_tag.missing <= !(geo_valid_a && geo_valid_b);
      s1_mdlat <= dlat[24] ? 25'(-dlat) : 25'(dlat);
      s1_mdlon <= dlon[25] ? 26'(-dlon) : 26'(dlon);
      s1_mla   <= lat_a[23] ? 24'(-lat_a) : 24'(lat_a);
      s1_mlb   <= lat_b[23] ? 24'(-lat_b) : 24'(lat_b);
    end
  end

  // Degrees to Q32 turns; half angles take one more shift.
  assign pm_dlat = 58'(s1_mdlat) * 58'(hav_pkg::DEG_TURN_K);
  assign pm_dlon = 58'(s1_mdlon) * 58'(hav_pkg::DEG_TURN_K);
  assign pm_la   = 58'(s1_mla) * 58'(hav_pkg::DEG_TURN_K);
  assign pm_lb   = 58'(s1_mlb) * 58'(hav_pkg::DEG_TURN_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else if (en) begin
      s2_tag   <= s1_tag;
      s2_pdlat <= 32'(pm_dlat >> (hav_pkg::ANGLE_FRAC_BITS + 9));
      s2_pdlon <= 32'(pm_dlon >> (hav_pkg::ANGLE_FRAC_BITS + 9));
      s2_pla   <= 32'(pm_la >> (hav_pkg::ANGLE_FRAC_BITS + 8));
      s2_plb   <= 32'(pm_lb >> (hav_pkg::ANGLE_FRAC_BITS + 8));
    end
  end

  // Position within the quadrant to radians.
  assign rm_dlat = 61'(s2_pdlat[29:0]) * 61'(hav_pkg::HALF_PI_Q30);
  assign rm_dlon = 61'(s2_pdlon[29:0]) * 61'(hav_pkg::HALF_PI_Q30);
  assign rm_la   = 61'(s2_pla[29:0]) * 61'(hav_pkg::HALF_PI_Q30);
  assign rm_lb   = 61'(s2_plb[29:0]) * 61'(hav_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_front.tag.valid <= 1'b0;
    end else if (en) begin
      s3_front.tag <= s2_tag;
      s3_front.qdl <= s2_pdlat[31:30];
      s3_front.qdn <= s2_pdlon[31:30];
      s3_front.qa  <= s2_pla[31:30];
      s3_front.qb  <= s2_plb[31:30];
      s3_tdlat <= rm_dlat[60:30];
      s3_tdlon <= rm_dlon[60:30];
      s3_tla   <= rm_la[60:30];
      s3_tlb   <= rm_lb[60:30];
    end
  end

  hav_taylor u_tay_dlat (.clk(clk), .en(en), .theta(s3_tdlat), .sin_q(sin_dl), .cos_q(cos_dl));
  hav_taylor u_tay_dlon (.clk(clk), .en(en), .theta(s3_tdlon), .sin_q(sin_dn), .cos_q(cos_dn));
  hav_taylor u_tay_la   (.clk(clk), .en(en), .theta(s3_tla), .sin_q(sin_a), .cos_q(cos_a));
  hav_taylor u_tay_lb   (.clk(clk), .en(en), .theta(s3_tlb), .sin_q(sin_b), .cos_q(cos_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        fl[i].tag.valid <= 1'b0;
      end
    end else if (en) begin
      fl[0] <= s3_front;
      for (int i = 1; i < LAT; i++) begin
        fl[i] <= fl[i-1];
      end
    end
  end

  // Odd quadrants swap sine and cosine; the second and third negate cosine.
  assign sel_dl = fl[LAT-1].qdl[0] ? cos_dl : sin_dl;
  assign sel_dn = fl[LAT-1].qdn[0] ? cos_dn : sin_dn;
  assign sel_a  = fl[LAT-1].qa[0] ? sin_a : cos_a;
  assign sel_b  = fl[LAT-1].qb[0] ? sin_b : cos_b;
  assign sq_dl  = 62'(sel_dl) * 62'(sel_dl);
  assign sq_dn  = 62'(sel_dn) * 62'(sel_dn);
  assign pr_ab  = 62'(sel_a) * 62'(sel_b);
  assign pr_h   = 62'(s4_cc) * 62'(s4_so2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag.valid <= 1'b0;
      s5_tag.valid <= 1'b0;
      root_in.tag.valid <= 1'b0;
    end else if (en) begin
      s4_tag <= fl[LAT-1].tag;
      s4_sd2 <= sq_dl[60:30];
      s4_so2 <= sq_dn[60:30];
      s4_cc  <= pr_ab[60:30];
      s4_neg <= (fl[LAT-1].qa[1] ^ fl[LAT-1].qa[0]) ^
                (fl[LAT-1].qb[1] ^ fl[LAT-1].qb[0]);

      s5_tag  <= s4_tag;
      s5_sd2  <= s4_sd2;
      s5_prod <= pr_h[60:30];
      s5_neg  <= s4_neg;

      root_in.tag    <= s5_tag;
      root_in.u.rad  <= {1'b0, h, 30'b0};
      root_in.u.rem  <= '0;
      root_in.u.root <= '0;
      root_in.v.rad  <= {1'b0, hav_pkg::ONE_Q30 - h, 30'b0};
      root_in.v.rem  <= '0;
      root_in.v.root <= '0;
    end
  end

  // h, clamped to the unit range.
  assign hv = s5_neg ? $signed({2'b00, s5_sd2}) - $signed({2'b00, s5_prod})
                     : $signed({2'b00, s5_sd2}) + $signed({2'b00, s5_prod});
  assign h  = (hv < 0) ? '0 :
              (hv > $signed(33'(hav_pkg::ONE_Q30))) ? hav_pkg::ONE_Q30 : hv[30:0];

  // Square roots of h and 1 - h.
  assign root_c[0] = root_in;

  for (genvar k = 0; k < NR; k++) begin : g_root
    hav_root_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (root_c[k]),
      .d_out (root_c[k+1])
    );
  end

  // Half the central angle, one bit per cell from the top down.
  assign srch_c[0] = '{tag:   root_c[NR].tag,
                       theta: '0,
                       mask:  hav_pkg::SEARCH_MSB,
                       u:     root_c[NR].u.root,
                       v:     root_c[NR].v.root};

  for (genvar k = 0; k < NS; k++) begin : g_search
    hav_search_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (srch_c[k]),
      .d_out (srch_c[k+1])
    );
  end

  // Scale by the radius, round half up and saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_tag.valid <= 1'b0;
    end else if (en) begin
      p1_tag  <= srch_c[NS].tag;
      p1_prod <= 44'(earth_radius_km) * 44'(srch_c[NS].theta);
    end
  end

  assign rnd      = 45'(p1_prod) + hav_pkg::DIST_ROUND;
  assign dist_sat = p1_tag.missing ? '0 :
                    (rnd[44:21] > 24'(hav_pkg::DIST_MAX)) ? hav_pkg::DIST_MAX : rnd[43:21];

  // A finished item goes to the output register, or to the skid register
  // while the output waits; a full skid register holds the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!out_valid || out_ready) begin
        out_valid   <= p1_tag.valid;
        distance_km <= dist_sat;
        missing     <= p1_tag.missing;
      end else if (p1_tag.valid) begin
        skid_valid   <= 1'b1;
        skid_dist    <= dist_sat;
        skid_missing <= p1_tag.missing;
      end
    end else if (out_ready) begin
      distance_km <= skid_dist;
      missing     <= skid_missing;
      skid_valid  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_taylor.sv
`default_nettype none

// Pipelined sine and cosine series of a Q30 angle in radians.
module hav_taylor (
  input  logic          clk,
  input  logic          en,
  input  hav_pkg::q30_t theta,
  output hav_pkg::q30_t sin_q,
  output hav_pkg::q30_t cos_q
);

  localparam int N = hav_pkg::TERMS;

  logic [31:0]        x2_c [0:N];
  logic [31:0]        ts_c [0:N];
  logic [31:0]        tc_c [0:N];
  logic signed [33:0] as_c [0:N];
  logic signed [33:0] ac_c [0:N];
  logic [61:0]        sq;

  function automatic hav_pkg::q30_t clamp(input logic signed [33:0] a);
    hav_pkg::q30_t r;
    if (a < 0) begin
      r = '0;
    end else if (a > $signed(34'(hav_pkg::ONE_Q30))) begin
      r = hav_pkg::ONE_Q30;
    end else begin
      r = a[30:0];
    end
    return r;
  endfunction

  assign sq = 62'(theta) * 62'(theta);

  // Square of the angle and the first terms of both series.
  always_ff @(posedge clk) begin
    if (en) begin
      x2_c[0] <= sq[61:30];
      ts_c[0] <= 32'(theta);
      tc_c[0] <= 32'(hav_pkg::ONE_Q30);
      as_c[0] <= $signed(34'(theta));
      ac_c[0] <= $signed(34'(hav_pkg::ONE_Q30));
    end
  end

  // One cell per term: multiply by x^2, estimate the quotient, correct it.
  for (genvar k = 0; k < N; k++) begin : g_term
    logic [31:0]        xa, nas, nac, xb, nbs, nbc, pbs, pbc, qs, qc;
    logic signed [33:0] asa, aca, asb, acb;
    logic [63:0]        mas, mac;
    logic [62:0]        mbs, mbc;
    logic [33:0]        rs, rc;

    assign mas = 64'(ts_c[k]) * 64'(x2_c[k]);
    assign mac = 64'(tc_c[k]) * 64'(x2_c[k]);
    assign mbs = 63'(nas) * 63'(hav_pkg::SIN_RECIP[k]);
    assign mbc = 63'(nac) * 63'(hav_pkg::COS_RECIP[k]);
    assign rs  = 34'(nbs) - 34'(pbs) * 34'(hav_pkg::SIN_DIV[k]);
    assign rc  = 34'(nbc) - 34'(pbc) * 34'(hav_pkg::COS_DIV[k]);
    assign qs  = pbs + 32'(rs >= 34'(hav_pkg::SIN_DIV[k]))
                     + 32'(rs >= (34'(hav_pkg::SIN_DIV[k]) << 1));
    assign qc  = pbc + 32'(rc >= 34'(hav_pkg::COS_DIV[k]))
                     + 32'(rc >= (34'(hav_pkg::COS_DIV[k]) << 1));

    always_ff @(posedge clk) begin
      if (en) begin
        xa  <= x2_c[k];
        nas <= mas[61:30];
        nac <= mac[61:30];
        asa <= as_c[k];
        aca <= ac_c[k];

        xb  <= xa;
        nbs <= nas;
        nbc <= nac;
        pbs <= mbs[62:31];
        pbc <= mbc[62:31];
        asb <= asa;
        acb <= aca;

        x2_c[k+1] <= xb;
        ts_c[k+1] <= qs;
        tc_c[k+1] <= qc;
        if (k % 2 == 0) begin
          as_c[k+1] <= asb - $signed({2'b00, qs});
          ac_c[k+1] <= acb - $signed({2'b00, qc});
        end else begin
          as_c[k+1] <= asb + $signed({2'b00, qs});
          ac_c[k+1] <= acb + $signed({2'b00, qc});
        end
      end
    end
  end

  // Both sums are clamped to the unit range.
  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= clamp(as_c[N]);
      cos_q <= clamp(ac_c[N]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_root_cell.sv
`default_nettype none

// One digit step of two integer square roots, two radicand bits per step.
module hav_root_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hav_pkg::root_item_t d_in,
  output hav_pkg::root_item_t d_out
);

  function automatic hav_pkg::root_lane_t step(input hav_pkg::root_lane_t a);
    hav_pkg::root_lane_t b;
    logic [33:0]         rem2;
    logic [32:0]         trial;
    rem2  = {a.rem, a.rad[61:60]};
    trial = {a.root, 2'b01};
    b.rad = {a.rad[59:0], 2'b00};
    if (rem2 >= 34'(trial)) begin
      b.rem  = 32'(rem2 - 34'(trial));
      b.root = {a.root[29:0], 1'b1};
    end else begin
      b.rem  = 32'(rem2);
      b.root = {a.root[29:0], 1'b0};
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.tag.valid <= 1'b0;
    end else if (en) begin
      d_out.tag <= d_in.tag;
      d_out.u   <= step(d_in.u);
      d_out.v   <= step(d_in.v);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_search_cell.sv
`default_nettype none

// One bit of the half-central-angle search: evaluates the candidate angle
// and keeps it when it is at most pi/2 and sin(cand) * v <= cos(cand) * u.
module hav_search_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  hav_pkg::search_item_t d_in,
  output hav_pkg::search_item_t d_out
);

  localparam int L = hav_pkg::TAYLOR_LAT;

  typedef struct packed {
    hav_pkg::search_item_t item;
    hav_pkg::q30_t         cand;
    logic                  over;
  } hold_t;

  hav_pkg::q30_t cand, sin_q, cos_q;
  logic          over;
  hold_t         line [0:L-1];
  hold_t         mul_r;
  logic [61:0]   ps, pc;

  assign cand = d_in.theta | d_in.mask;
  assign over = cand > hav_pkg::HALF_PI_Q30;

  hav_taylor u_taylor (
    .clk   (clk),
    .en    (en),
    .theta (cand),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  // The item waits beside the series pipeline, then the two products
  // are formed and compared.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) begin
        line[i].item.tag.valid <= 1'b0;
      end
      mul_r.item.tag.valid <= 1'b0;
      d_out.tag.valid      <= 1'b0;
    end else if (en) begin
      line[0] <= '{item: d_in, cand: cand, over: over};
      for (int i = 1; i < L; i++) begin
        line[i] <= line[i-1];
      end
      mul_r <= line[L-1];
      ps    <= 62'(sin_q) * 62'(line[L-1].item.v);
      pc    <= 62'(cos_q) * 62'(line[L-1].item.u);
      d_out <= '{tag:   mul_r.item.tag,
                 theta: (!mul_r.over && ps <= pc) ? mul_r.cand : mul_r.item.theta,
                 mask:  mul_r.item.mask >> 1,
                 u:     mul_r.item.u,
                 v:     mul_r.item.v};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks of the distance block.
module hav_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [22:0]        distance_km,
  input logic               missing,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // An item without data always reports a zero distance.
  `HAV_ASSERT(a_missing_zero, out_valid && missing |-> distance_km == 23'd0, "missing item with nonzero distance")

  // The input side only stalls while a result waits at the output.
  `HAV_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with no result waiting")

  // A stalled result holds.
  `HAV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(distance_km) && $stable(missing), "stalled result changed")

  // A radius write reads back on the next cycle.
  `HAV_ASSERT(a_radius_rb, psel && penable && pwrite && !paddr[2] ##1 !paddr[2] |-> prdata == 32'($past(pwdata[12:0])), "radius readback mismatch")

  // The register port never waits.
  `HAV_ALWAYS(a_pready, pready, "pready low")

endmodule

bind haversine_great_circle_distance hav_checker u_hav_checker (.*);

`default_nettype wire
